// ===== hdl/mialu_pkg.sv =====
// Package for the MIPS III integer ALU with HI/LO: opcodes, payload structs,
// FSM states and helpers. No dependencies.
package mialu_pkg;

  localparam int REG_COUNT = 32;
  localparam int RIDX_W = $clog2(REG_COUNT);
  localparam int XLEN = 64;

  typedef enum logic [5:0] {
    OP_SRA = 6'd0, OP_SRL = 6'd1, OP_SLL = 6'd2, OP_SRAV = 6'd3, OP_SRLV = 6'd4,
    OP_SLLV = 6'd5, OP_MFHI = 6'd6, OP_MFLO = 6'd7, OP_MTHI = 6'd8, OP_MTLO = 6'd9,
    OP_ADD = 6'd10, OP_SUB = 6'd11, OP_ADDU = 6'd12, OP_SUBU = 6'd13, OP_AND = 6'd14,
    OP_OR = 6'd15, OP_XOR = 6'd16, OP_NOR = 6'd17, OP_MULT = 6'd18, OP_MULTU = 6'd19,
    OP_DIV = 6'd20, OP_DIVU = 6'd21, OP_SLT = 6'd22, OP_SLTU = 6'd23, OP_SLTI = 6'd24,
    OP_SLTIU = 6'd25, OP_DADDI = 6'd26, OP_DADDIU = 6'd27, OP_DADD = 6'd28,
    OP_DSUB = 6'd29, OP_DADDU = 6'd30, OP_DSUBU = 6'd31, OP_DMULT = 6'd32,
    OP_DMULTU = 6'd33, OP_DDIV = 6'd34, OP_DDIVU = 6'd35, OP_ANDI = 6'd36,
    OP_ORI = 6'd37, OP_XORI = 6'd38
  } op_t;

  typedef struct packed {
    logic [5:0]  mode;
    logic [4:0]  src_a_reg;
    logic [4:0]  src_b_reg;
    logic [4:0]  dest_reg;
    logic [4:0]  shift_amount;
    logic [15:0] immediate;
  } in_word_t;

  typedef struct packed {
    logic        reg_written;
    logic [4:0]  written_reg;
    logic [63:0] written_value;
    logic [63:0] hi_value;
    logic [63:0] lo_value;
    logic        divide_by_zero;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_DONE
  } state_t;

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

// ===== hdl/mips_integer_alu_hi_lo.sv =====
// Top level of the MIPS III integer ALU with HI/LO register pair.
// Depends on mialu_pkg.
//
// One instruction word in, one result word out. The 32 x 64 register file is
// a synchronous RAM with two read ports, addressed by the source indexes of
// a word at the edge that takes it. The sequencer then passes through a read
// state for the read data, an execute state, and a done state that loads the
// result register, and returns to idle, where the next word can be taken.
// Multiplies add sixteen 16x64 partial-product steps after execute. Divides
// use a radix-2 restoring divider, one quotient bit per cycle over 32 or 64
// bits. A divide by zero skips the divider. While the result register holds
// a stalled word, the sequencer waits in its last state and the input stays
// stalled. One word is in flight at a time, so no forwarding is needed. The
// register file needs no clearing pass: per-entry valid bits make unwritten
// entries read as zero, and entry 0 is never written.
module mips_integer_alu_hi_lo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mialu_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mialu_pkg::out_word_t out_data
);
  import mialu_pkg::*;

  state_t state_r, state_nxt;
  in_word_t cmd_r;
  logic [63:0] rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_r;
  logic [63:0] rda_r, rdb_r, a, b;
  logic rda_v_r, rdb_v_r;
  logic [63:0] hi_r, lo_r;
  out_word_t res_r;
  logic out_valid_r;

  // multiply / divide datapath
  logic [127:0] acc_r;
  logic [63:0] mb_r, ma_r;
  logic [6:0] cnt_r;
  logic [63:0] dvs_r, rem_r, quo_r;
  logic neg_q_r, neg_r_r, wide_r;

  op_t op;
  assign op = op_t'(cmd_r.mode);

  logic take, rf_we;
  logic [4:0] rf_wa;
  logic [63:0] rf_wd;
  assign take = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = res_r;

  // register file RAM: read at the two source indexes of a taken word
  always_ff @(posedge clk) begin
    if (take) begin
      rda_r <= rf_mem[in_data.src_a_reg];
      rdb_r <= rf_mem[in_data.src_b_reg];
    end
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      rda_v_r <= 1'b0;
      rdb_v_r <= 1'b0;
    end else begin
      if (take) begin
        rda_v_r <= rf_vld_r[in_data.src_a_reg];
        rdb_v_r <= rf_vld_r[in_data.src_b_reg];
      end
      if (rf_we) rf_vld_r[rf_wa] <= 1'b1;
    end
  end

  // entry 0 is never marked valid, so it reads zero
  assign a = rda_v_r ? rda_r : '0;
  assign b = rdb_v_r ? rdb_r : '0;

  // execute for operations outside the multiplier and divider
  logic wr_c;
  logic [4:0] dst_c;
  logic [63:0] val_c;
  logic [4:0] vsh;
  logic [63:0] simm;
  logic [31:0] b32;
  assign vsh = a[4:0];
  assign simm = sx16(cmd_r.immediate);
  assign b32 = b[31:0];

  always_comb begin
    wr_c = 1'b1;
    dst_c = cmd_r.dest_reg;
    val_c = '0;
    case (op) inside
      OP_SRA:  val_c = sx32(32'($signed(b32) >>> cmd_r.shift_amount));
      OP_SRL:  val_c = sx32(b32 >> cmd_r.shift_amount);
      OP_SLL:  val_c = sx32(b32 << cmd_r.shift_amount);
      OP_SRAV: val_c = sx32(32'($signed(b32) >>> vsh));
      OP_SRLV: val_c = sx32(b32 >> vsh);
      OP_SLLV: val_c = sx32(b32 << vsh);
      OP_MFHI: val_c = hi_r;
      OP_MFLO: val_c = lo_r;
      OP_ADD, OP_ADDU: val_c = sx32(a[31:0] + b32);
      OP_SUB, OP_SUBU: val_c = sx32(a[31:0] - b32);
      OP_AND:  val_c = a & b;
      OP_OR:   val_c = a | b;
      OP_XOR:  val_c = a ^ b;
      OP_NOR:  val_c = ~(a | b);
      OP_SLT:  val_c = {63'd0, $signed(a) < $signed(b)};
      OP_SLTU: val_c = {63'd0, a < b};
      OP_SLTI: begin dst_c = cmd_r.src_b_reg; val_c = {63'd0, $signed(a) < $signed(simm)}; end
      OP_SLTIU: begin dst_c = cmd_r.src_b_reg; val_c = {63'd0, a < simm}; end
      OP_DADDI, OP_DADDIU: begin dst_c = cmd_r.src_b_reg; val_c = a + simm; end
      OP_DADD, OP_DADDU: val_c = a + b;
      OP_DSUB, OP_DSUBU: val_c = a - b;
      OP_ANDI: begin dst_c = cmd_r.src_b_reg; val_c = a & {48'd0, cmd_r.immediate}; end
      OP_ORI:  begin dst_c = cmd_r.src_b_reg; val_c = a | {48'd0, cmd_r.immediate}; end
      OP_XORI: begin dst_c = cmd_r.src_b_reg; val_c = a ^ {48'd0, cmd_r.immediate}; end
      default: wr_c = 1'b0;
    endcase
    if (dst_c == '0) begin
      wr_c = 1'b0;
    end
    if (!wr_c) begin
      dst_c = '0;
      val_c = '0;
    end
  end

  logic is_mul, is_div, mul_sgn, mul_w, div_w, div_s, dz_c;
  logic [63:0] ma_c, mb_c, dn_c, dd_c, dn_mag;
  always_comb begin
    is_mul = (op == OP_MULT) || (op == OP_MULTU) || (op == OP_DMULT) || (op == OP_DMULTU);
    is_div = (op == OP_DIV) || (op == OP_DIVU) || (op == OP_DDIV) || (op == OP_DDIVU);
    mul_w = (op == OP_DMULT) || (op == OP_DMULTU);
    mul_sgn = (op == OP_MULT) || (op == OP_DMULT);
    div_w = (op == OP_DDIV) || (op == OP_DDIVU);
    div_s = (op == OP_DIV) || (op == OP_DDIV);
    // 32-bit multiplies run as 64-bit ones on sign/zero-extended operands
    ma_c = mul_w ? a : (mul_sgn ? sx32(a[31:0]) : {32'd0, a[31:0]});
    mb_c = mul_w ? b : (mul_sgn ? sx32(b32) : {32'd0, b32});
    dn_c = div_w ? a : (div_s ? sx32(a[31:0]) : {32'd0, a[31:0]});
    dd_c = div_w ? b : (div_s ? sx32(b32) : {32'd0, b32});
    dn_mag = (div_s && dn_c[63]) ? (64'd0 - dn_c) : dn_c;
    dz_c = (dd_c == '0);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (take) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (is_mul) state_nxt = ST_MUL;
        else if (is_div && !dz_c) state_nxt = ST_DIV;
        else state_nxt = ST_DONE;
      end
      ST_MUL: if (cnt_r == 7'd15) state_nxt = ST_DONE;
      ST_DIV: if (cnt_r == (wide_r ? 7'd63 : 7'd31)) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    rf_we = (state_r == ST_EXEC) && wr_c;
    rf_wa = dst_c;
    rf_wd = val_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (take) cmd_r <= in_data;
  end

  // multiply step: 16 bits of the multiplier per cycle into a 128-bit sum
  logic [79:0] pp;
  assign pp = mb_r[15:0] * ma_r;

  // divide step: shift one numerator bit into the partial remainder
  logic [64:0] trial;
  logic [64:0] rsh;
  assign rsh = {rem_r, quo_r[63]};
  assign trial = rsh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r <= '0;
      lo_r <= '0;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      // load the result register once it is free, drop valid when taken
      if (state_r == ST_DONE && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_EXEC: begin
          cnt_r <= '0;
          if (op == OP_MTHI) hi_r <= a;
          if (op == OP_MTLO) lo_r <= a;
          acc_r <= '0;
          ma_r <= ma_c;
          mb_r <= mb_c;
          wide_r <= div_w;
          dvs_r <= (div_s && dd_c[63]) ? (64'd0 - dd_c) : dd_c;
          // align a 32-bit numerator to the top for 32 steps
          quo_r <= div_w ? dn_mag : {dn_mag[31:0], 32'd0};
          rem_r <= '0;
          neg_q_r <= div_s && (dn_c[63] != dd_c[63]);
          neg_r_r <= div_s && dn_c[63];
        end
        ST_MUL: begin
          acc_r <= acc_r + ({48'd0, pp} << {cnt_r[3:0], 4'd0});
          mb_r <= {16'd0, mb_r[63:16]};
          cnt_r <= cnt_r + 7'd1;
        end
        ST_DIV: begin
          cnt_r <= cnt_r + 7'd1;
          if (!trial[64]) begin
            rem_r <= trial[63:0];
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= rsh[63:0];
            quo_r <= {quo_r[62:0], 1'b0};
          end
        end
        ST_DONE: begin
          // command and operands hold until the next take, so the write
          // fields computed in execute are still good here
          if (!out_valid_r || !out_stall) begin
            res_r.reg_written <= wr_c;
            res_r.written_reg <= dst_c;
            res_r.written_value <= val_c;
            res_r.divide_by_zero <= is_div && dz_c;
            res_r.hi_value <= hi_r;
            res_r.lo_value <= lo_r;
          end
        end
        default: ;
      endcase
      // commit products and quotients on the last step
      if (state_r == ST_MUL && cnt_r == 7'd15) begin
        logic [127:0] full;
        logic [63:0] hh;
        full = acc_r + ({48'd0, pp} << 8'd240);
        hh = full[127:64];
        // signed 64-bit: subtract cross terms from the high half
        if (op == OP_DMULT) begin
          if (ma_r[63]) hh = hh - mb_c;
          if (mb_c[63]) hh = hh - ma_r;
        end
        if (op == OP_DMULT || op == OP_DMULTU) begin
          hi_r <= hh;
          lo_r <= full[63:0];
        end else begin
          hi_r <= sx32(full[63:32]);
          lo_r <= sx32(full[31:0]);
        end
      end
      if (state_r == ST_DIV && cnt_r == (wide_r ? 7'd63 : 7'd31)) begin
        logic [63:0] q, r;
        q = trial[64] ? {quo_r[62:0], 1'b0} : {quo_r[62:0], 1'b1};
        r = trial[64] ? rsh[63:0] : trial[63:0];
        if (neg_q_r) q = 64'd0 - q;
        if (neg_r_r) r = 64'd0 - r;
        if (wide_r) begin
          hi_r <= r;
          lo_r <= q;
        end else begin
          hi_r <= sx32(r[31:0]);
          lo_r <= sx32(q[31:0]);
        end
      end
    end
  end

endmodule

// ===== hdl/mialu_checker.sv =====
// Port-level checker for mips_integer_alu_hi_lo, bound to the top level.
// Depends on mialu_pkg.
module mialu_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input mialu_pkg::in_word_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input mialu_pkg::out_word_t out_data
);
  import mialu_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_r0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.reg_written || out_data.written_reg == '0))
    else $error("index without write");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("took a second word while busy");

  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_by_zero |-> !out_data.reg_written)
    else $error("divide flag with register write");
endmodule

bind mips_integer_alu_hi_lo mialu_checker u_chk (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for mips_integer_alu_hi_lo: an instruction predictor
// tracks the register file, HI and LO, and checks every result word.
// Depends on mialu_pkg and the mips_integer_alu_hi_lo RTL.
module testbench;
  import mialu_pkg::*;

  localparam int MAX_ERR_PRINTS = 10;
  // Far above the time a 64-bit divide word needs, to allow for result stalls.
  localparam int STUCK_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_WORDS = 1700;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;

  // Predicted architectural state.
  logic [63:0] gpr [REG_COUNT];
  logic [63:0] hi_reg;
  logic [63:0] lo_reg;

  out_word_t pending_results[$];
  int mismatch_count = 0;
  int stuck_cycles = 0;
  int stall_cycle = 0;

  mips_integer_alu_hi_lo u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] widen32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // Execute one instruction on the predicted state; return its result word.
  function automatic out_word_t execute_instr(input in_word_t w);
    logic [63:0] a, b, val, imm_sx, ua, ub, q, r;
    logic signed [63:0] sa64, sb64, sp;
    logic [127:0] prod;
    logic [31:0] t32;
    logic [4:0] vsh, dst;
    logic wr, dz;
    out_word_t res;
    a = (w.src_a_reg == 0) ? 64'd0 : gpr[w.src_a_reg];
    b = (w.src_b_reg == 0) ? 64'd0 : gpr[w.src_b_reg];
    imm_sx = {{48{w.immediate[15]}}, w.immediate};
    sa64 = widen32(a[31:0]);
    sb64 = widen32(b[31:0]);
    vsh = a[4:0];
    wr = 1'b1;
    dz = 1'b0;
    dst = w.dest_reg;
    val = '0;
    case (w.mode)
      OP_SRA: begin
        t32 = $signed(b[31:0]) >>> w.shift_amount;
        val = widen32(t32);
      end
      OP_SRL: val = widen32(b[31:0] >> w.shift_amount);
      OP_SLL: val = widen32(b[31:0] << w.shift_amount);
      OP_SRAV: begin
        t32 = $signed(b[31:0]) >>> vsh;
        val = widen32(t32);
      end
      OP_SRLV: val = widen32(b[31:0] >> vsh);
      OP_SLLV: val = widen32(b[31:0] << vsh);
      OP_MFHI: val = hi_reg;
      OP_MFLO: val = lo_reg;
      OP_MTHI: begin
        wr = 1'b0;
        hi_reg = a;
      end
      OP_MTLO: begin
        wr = 1'b0;
        lo_reg = a;
      end
      OP_ADD, OP_ADDU: val = widen32(a[31:0] + b[31:0]);
      OP_SUB, OP_SUBU: val = widen32(a[31:0] - b[31:0]);
      OP_AND: val = a & b;
      OP_OR: val = a | b;
      OP_XOR: val = a ^ b;
      OP_NOR: val = ~(a | b);
      OP_MULT: begin
        wr = 1'b0;
        sp = sa64 * sb64;
        lo_reg = widen32(sp[31:0]);
        hi_reg = widen32(sp[63:32]);
      end
      OP_MULTU: begin
        wr = 1'b0;
        q = {32'd0, a[31:0]} * {32'd0, b[31:0]};
        lo_reg = widen32(q[31:0]);
        hi_reg = widen32(q[63:32]);
      end
      OP_DIV: begin
        wr = 1'b0;
        if (b[31:0] == 0) begin
          dz = 1'b1;
        end else begin
          // 64-bit math lets the most-negative / -1 case wrap in the low word
          sp = sa64 / sb64;
          lo_reg = widen32(sp[31:0]);
          sp = sa64 % sb64;
          hi_reg = widen32(sp[31:0]);
        end
      end
      OP_DIVU: begin
        wr = 1'b0;
        if (b[31:0] == 0) begin
          dz = 1'b1;
        end else begin
          lo_reg = widen32(a[31:0] / b[31:0]);
          hi_reg = widen32(a[31:0] % b[31:0]);
        end
      end
      OP_SLT: val = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
      OP_SLTU: val = (a < b) ? 64'd1 : 64'd0;
      OP_SLTI: begin
        dst = w.src_b_reg;
        val = ($signed(a) < $signed(imm_sx)) ? 64'd1 : 64'd0;
      end
      OP_SLTIU: begin
        dst = w.src_b_reg;
        val = (a < imm_sx) ? 64'd1 : 64'd0;
      end
      OP_DADDI, OP_DADDIU: begin
        dst = w.src_b_reg;
        val = a + imm_sx;
      end
      OP_DADD, OP_DADDU: val = a + b;
      OP_DSUB, OP_DSUBU: val = a - b;
      OP_DMULT: begin
        wr = 1'b0;
        prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        hi_reg = prod[127:64];
        lo_reg = prod[63:0];
      end
      OP_DMULTU: begin
        wr = 1'b0;
        prod = {64'd0, a} * {64'd0, b};
        hi_reg = prod[127:64];
        lo_reg = prod[63:0];
      end
      OP_DDIV: begin
        wr = 1'b0;
        if (b == 0) begin
          dz = 1'b1;
        end else begin
          // divide magnitudes, then restore signs; avoids signed overflow
          ua = a[63] ? -a : a;
          ub = b[63] ? -b : b;
          q = ua / ub;
          r = ua % ub;
          lo_reg = (a[63] != b[63]) ? -q : q;
          hi_reg = a[63] ? -r : r;
        end
      end
      OP_DDIVU: begin
        wr = 1'b0;
        if (b == 0) begin
          dz = 1'b1;
        end else begin
          lo_reg = a / b;
          hi_reg = a % b;
        end
      end
      OP_ANDI: begin
        dst = w.src_b_reg;
        val = a & {48'd0, w.immediate};
      end
      OP_ORI: begin
        dst = w.src_b_reg;
        val = a | {48'd0, w.immediate};
      end
      OP_XORI: begin
        dst = w.src_b_reg;
        val = a ^ {48'd0, w.immediate};
      end
      default: wr = 1'b0;
    endcase
    // Writes to register 0 are dropped and reported as no write.
    if (wr && dst != 0) begin
      gpr[dst] = val;
    end else begin
      wr = 1'b0;
      dst = '0;
      val = '0;
    end
    res.reg_written = wr;
    res.written_reg = dst;
    res.written_value = val;
    res.hi_value = hi_reg;
    res.lo_value = lo_reg;
    res.divide_by_zero = dz;
    return res;
  endfunction

  function automatic in_word_t instr(input logic [5:0] op, input logic [4:0] rs,
                                     input logic [4:0] rt, input logic [4:0] rd,
                                     input logic [4:0] sa, input logic [15:0] imm);
    in_word_t w;
    w.mode = op;
    w.src_a_reg = rs;
    w.src_b_reg = rt;
    w.dest_reg = rd;
    w.shift_amount = sa;
    w.immediate = imm;
    return w;
  endfunction

  // Present one word, hold it until taken, then record its expected result.
  // Valid stays high on return so back-to-back words need no re-raise.
  task automatic issue_instr(input in_word_t w);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(execute_instr(w));
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Build the extremes in registers, then hit the special cases.
  task automatic test_corner_values();
    issue_instr(instr(OP_DADDIU, 5'd0, 5'd1, 5'd0, 5'd0, 16'hFFFF)); // r1 = all ones
    issue_instr(instr(OP_SLL, 5'd0, 5'd1, 5'd2, 5'd31, 16'h0));      // r2 = sx(0x80000000)
    issue_instr(instr(OP_XOR, 5'd1, 5'd2, 5'd3, 5'd0, 16'h0));       // r3 = 0x7FFFFFFF
    issue_instr(instr(OP_DADDIU, 5'd3, 5'd4, 5'd0, 5'd0, 16'h0001)); // r4 = 0x80000000
    issue_instr(instr(OP_DADDU, 5'd4, 5'd4, 5'd5, 5'd0, 16'h0));     // r5 = 1 << 32
    issue_instr(instr(OP_DMULTU, 5'd4, 5'd5, 5'd0, 5'd0, 16'h0));    // lo = 1 << 63
    issue_instr(instr(OP_MFLO, 5'd0, 5'd0, 5'd6, 5'd0, 16'h0));      // r6 = most negative
    issue_instr(instr(OP_DADDIU, 5'd6, 5'd7, 5'd0, 5'd0, 16'hFFFF)); // r7 = most positive
    issue_instr(instr(OP_DDIV, 5'd6, 5'd1, 5'd0, 5'd0, 16'h0));      // 64-bit overflow
    issue_instr(instr(OP_DIV, 5'd2, 5'd1, 5'd0, 5'd0, 16'h0));       // 32-bit overflow
    issue_instr(instr(OP_DIV, 5'd1, 5'd5, 5'd0, 5'd0, 16'h0));       // low word zero
    issue_instr(instr(OP_DDIVU, 5'd1, 5'd0, 5'd0, 5'd0, 16'h0));     // divide by zero
    issue_instr(instr(OP_DMULT, 5'd6, 5'd6, 5'd0, 5'd0, 16'h0));
    issue_instr(instr(OP_MULT, 5'd2, 5'd2, 5'd0, 5'd0, 16'h0));
    issue_instr(instr(OP_MULTU, 5'd1, 5'd1, 5'd0, 5'd0, 16'h0));
    issue_instr(instr(OP_ADD, 5'd1, 5'd1, 5'd0, 5'd0, 16'h0));       // write to r0 dropped
    issue_instr(instr(OP_MTHI, 5'd7, 5'd0, 5'd0, 5'd0, 16'h0));
    issue_instr(instr(OP_MTLO, 5'd6, 5'd0, 5'd0, 5'd0, 16'h0));
    issue_instr(instr(OP_MFHI, 5'd0, 5'd0, 5'd8, 5'd0, 16'h0));
    issue_instr(instr(OP_SRAV, 5'd1, 5'd2, 5'd9, 5'd0, 16'h0));      // rs low bits = 31
    issue_instr(instr(OP_SRLV, 5'd1, 5'd2, 5'd10, 5'd0, 16'h0));
    issue_instr(instr(OP_SLLV, 5'd7, 5'd1, 5'd11, 5'd0, 16'h0));
    issue_instr(instr(6'd63, 5'd31, 5'd31, 5'd31, 5'd31, 16'hFFFF)); // unused code
    issue_instr(instr(OP_SLTI, 5'd6, 5'd12, 5'd0, 5'd0, 16'h8000));
    issue_instr(instr(OP_SLTIU, 5'd7, 5'd13, 5'd0, 5'd0, 16'hFFFF));
    issue_instr(instr(OP_XORI, 5'd1, 5'd14, 5'd0, 5'd0, 16'hFFFF));
  endtask

  // Run every opcode once on random registers.
  task automatic test_every_op();
    for (int op = OP_SRA; op <= OP_XORI; op++) begin
      issue_instr(instr(6'(op), 5'($urandom), 5'($urandom), 5'($urandom),
                        5'($urandom), 16'($urandom)));
    end
  endtask

  // Stop issuing until every outstanding result has drained.
  task automatic test_drain_pause();
    idle_sender(1);
    wait (pending_results.size() == 0);
    @(posedge clk);
    issue_instr(instr(OP_MFHI, 5'd0, 5'd0, 5'd15, 5'd0, 16'h0));
    issue_instr(instr(OP_MFLO, 5'd0, 5'd0, 5'd16, 5'd0, 16'h0));
  endtask

  // Random words in bursts; mostly valid opcodes with some unused codes.
  // Seed registers often so values stay wide and varied.
  task automatic test_random_stream();
    int sent;
    int burst;
    int pick;
    in_word_t w;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst; k++) begin
        w = instr(6'($urandom_range(OP_SRA, OP_XORI)), 5'($urandom), 5'($urandom),
                  5'($urandom), 5'($urandom), 16'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          w.mode = 6'($urandom_range(39, 63));
        end else if (pick < 15) begin
          w.mode = (pick < 10) ? OP_DMULTU : OP_MFLO;
        end else if (pick < 22) begin
          w.mode = OP_DADDIU;
        end else if (pick < 26) begin
          w.src_b_reg = 5'd0; // zero divisor or zero operand
        end
        issue_instr(w);
        sent++;
      end
      // Leave long stretches with no gaps at all.
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(0, 8));
    end
    idle_sender(1);
  endtask

  // Result side: stall on a pattern that rotates through four phases.
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    case ((stall_cycle / 64) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= (stall_cycle % 3 == 0);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // Compare each taken result word with the oldest prediction.
  always @(posedge clk) begin : result_check
    out_word_t exp_word;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < MAX_ERR_PRINTS)
          $display("unexpected result word %p", out_data);
        mismatch_count++;
      end else begin
        exp_word = pending_results.pop_front();
        if (out_data.reg_written !== exp_word.reg_written ||
            out_data.written_reg !== exp_word.written_reg ||
            out_data.written_value !== exp_word.written_value ||
            out_data.hi_value !== exp_word.hi_value ||
            out_data.lo_value !== exp_word.lo_value ||
            out_data.divide_by_zero !== exp_word.divide_by_zero) begin
          if (mismatch_count < MAX_ERR_PRINTS) begin
            $display("mismatch: expected wr=%0b reg=%0d val=%h hi=%h lo=%h dz=%0b",
                     exp_word.reg_written, exp_word.written_reg,
                     exp_word.written_value, exp_word.hi_value,
                     exp_word.lo_value, exp_word.divide_by_zero);
            $display("          actual   wr=%0b reg=%0d val=%h hi=%h lo=%h dz=%0b",
                     out_data.reg_written, out_data.written_reg,
                     out_data.written_value, out_data.hi_value,
                     out_data.lo_value, out_data.divide_by_zero);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no word moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("mips_integer_alu_hi_lo regression: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < REG_COUNT; i++) gpr[i] = '0;
    hi_reg = '0;
    lo_reg = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_values();
    test_every_op();
    test_drain_pause();
    test_random_stream();
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("mips_integer_alu_hi_lo regression: pass");
    end else begin
      $display("mips_integer_alu_hi_lo regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mialu_pkg.sv
hdl/mips_integer_alu_hi_lo.sv
hdl/mialu_checker.sv
test/testbench.sv
